### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the symbolizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Checks that a condition at one edge implies another at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/dcrl_pkg.sv
// Package with the types and constants of the coefficient run-length symbolizer.
`timescale 1ns / 1ps

package dcrl_pkg;

    localparam int COEF_W                     = 16;
    localparam int SYM_W                      = 8;
    localparam int RUN_W                      = 6;
    localparam int DEFAULT_BLOCK_COEFFICIENTS = 64;
    localparam int QUEUE_DEPTH                = 4;
    localparam int QPTR_W                     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W                     = $clog2(QUEUE_DEPTH + 1);
    localparam int SIDX_W                     = 2;
    localparam int SCNT_W                     = 3;

    localparam logic [SYM_W-1:0] EOB_SYMBOL = 8'hFF;
    localparam logic [RUN_W-1:0] RUN_MAX    = 6'd63;

    // Work for the back end from one coefficient.
    typedef struct packed {
        logic [COEF_W-1:0] folded;
        logic [RUN_W-1:0]  run;
        logic              is_dc;
        logic              is_ac;
        logic              eob;
    } t_rec;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    function automatic logic [COEF_W-1:0] fold16(input logic [COEF_W-1:0] d);
        return {d[COEF_W-2:0], 1'b0} ^ {COEF_W{d[COEF_W-1]}};
    endfunction

endpackage

### hw/rtl/dct_coefficient_run_length_symbolizer.sv
// Top level of the DCT coefficient DC-delta and AC run-length symbolizer.
//
//  Channel  Direction  Handshake           Beat
//  input    in         i_valid / o_ready   i_coefficient, i_frame_start
//  output   out        o_valid / i_ready   o_symbol, o_last_of_item, o_block_end
//
// A coefficient is accepted whenever the four-entry record queue is not full.
// The output stage sends one symbol per cycle while i_ready is high and records are waiting;
// a coefficient makes zero to four symbols, and the output side sets the sustained rate.
// Each record passes the queue and then the registered output stage before its symbols appear.
// Reset is synchronous and clears position, DC predictor, zero run and queue.
// Either side may stall; the queue lets the front keep accepting while symbols wait.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dct_coefficient_run_length_symbolizer #(
    parameter int BLOCK_COEFFICIENTS = dcrl_pkg::DEFAULT_BLOCK_COEFFICIENTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [dcrl_pkg::COEF_W-1:0] i_coefficient,
    input  logic                        i_frame_start,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [dcrl_pkg::SYM_W-1:0]  o_symbol,
    output logic                        o_last_of_item,
    output logic                        o_block_end
);
    import dcrl_pkg::*;

    t_rec      push_rec;
    t_rec      head_rec;
    t_q_status q_status;
    logic      push;
    logic      pop;

    dcrl_front #(
        .BLOCK_COEFFICIENTS(BLOCK_COEFFICIENTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_coefficient (i_coefficient),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_status.full),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    dcrl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_rec    (head_rec),
        .o_status (q_status)
    );

    dcrl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec          (head_rec),
        .i_empty        (q_status.empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_symbol       (o_symbol),
        .o_last_of_item (o_last_of_item),
        .o_block_end    (o_block_end)
    );

    `ASSERT_IMPLIES(a_eob_is_last, o_valid && o_block_end, o_last_of_item, "end of block not last")
    `ASSERT_IMPLIES(a_no_push_full, push, !q_status.full, "record pushed into full queue")
    `ASSERT_IMPLIES(a_no_pop_empty, pop, !q_status.empty, "record popped from empty queue")
    `ASSERT_ALWAYS(a_count_bound, q_status.count <= QCNT_W'(QUEUE_DEPTH), "queue count too high")

endmodule

### hw/rtl/dcrl_front.sv
// Front end: tracks block position, DC predictor and zero run, and builds work records.
`timescale 1ns / 1ps

module dcrl_front #(
    parameter int BLOCK_COEFFICIENTS = dcrl_pkg::DEFAULT_BLOCK_COEFFICIENTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dcrl_pkg::COEF_W-1:0]  i_coefficient,
    input  logic                         i_frame_start,
    input  logic                         i_q_full,
    output logic                         o_push,
    output dcrl_pkg::t_rec               o_rec
);
    import dcrl_pkg::*;

    localparam int POS_W = $clog2(BLOCK_COEFFICIENTS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_COEFFICIENTS - 1);

    logic [COEF_W-1:0] r_prev_dc, n_prev_dc;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [RUN_W-1:0]  r_run, n_run;
    logic [POS_W-1:0]  pos;
    logic [RUN_W-1:0]  run;
    logic [COEF_W-1:0] prev_dc;
    logic              accept;
    t_rec              rec;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        prev_dc   = i_frame_start ? '0 : r_prev_dc;
        pos       = i_frame_start ? '0 : r_pos;
        run       = i_frame_start ? '0 : r_run;
        n_prev_dc = prev_dc;
        n_run     = run;
        rec       = '0;
        if (pos == '0) begin
            rec.is_dc = 1'b1;
            rec.folded = fold16(i_coefficient - prev_dc);
            n_prev_dc = i_coefficient;
            n_run     = '0;
        end else if (i_coefficient == '0) begin
            if (run != RUN_MAX) begin
                n_run = run + RUN_W'(1);
            end
        end else begin
            rec.is_ac  = 1'b1;
            rec.run    = run;
            rec.folded = fold16(i_coefficient);
            n_run      = '0;
        end
        if (pos == POS_LAST) begin
            rec.eob = 1'b1;
            n_run   = '0;
            n_pos   = '0;
        end else begin
            n_pos = pos + POS_W'(1);
        end
    end

    assign o_rec  = rec;
    assign o_push = accept && (rec.is_dc || rec.is_ac || rec.eob);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_dc <= '0;
            r_pos     <= '0;
            r_run     <= '0;
        end else if (accept) begin
            r_prev_dc <= n_prev_dc;
            r_pos     <= n_pos;
            r_run     <= n_run;
        end
    end

endmodule

### hw/rtl/dcrl_queue.sv
// Short queue of work records between the front end and the back end.
`timescale 1ns / 1ps

module dcrl_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dcrl_pkg::t_rec      i_rec,
    input  logic                i_pop,
    output dcrl_pkg::t_rec      o_rec,
    output dcrl_pkg::t_q_status o_status
);
    import dcrl_pkg::*;

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_rec          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

### hw/rtl/dcrl_back.sv
// Back end: walks the symbols of the head record into a registered output stage.
`timescale 1ns / 1ps

module dcrl_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dcrl_pkg::t_rec             i_rec,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [dcrl_pkg::SYM_W-1:0] o_symbol,
    output logic                       o_last_of_item,
    output logic                       o_block_end
);
    import dcrl_pkg::*;

    logic [SIDX_W-1:0] r_idx;
    logic              r_valid;
    logic [SYM_W-1:0]  r_symbol;
    logic              r_last;
    logic              r_eob;
    logic [SCNT_W-1:0] count;
    logic [SYM_W-1:0]  symbol;
    logic              last;
    logic              advance;

    always_comb begin
        count = SCNT_W'(i_rec.eob);
        if (i_rec.is_dc) begin
            count = count + SCNT_W'(2);
        end else if (i_rec.is_ac) begin
            count = count + SCNT_W'(3);
        end
        symbol = EOB_SYMBOL;
        if (i_rec.is_dc) begin
            unique case (r_idx)
                2'd0:    symbol = i_rec.folded[15:8];
                2'd1:    symbol = i_rec.folded[7:0];
                default: symbol = EOB_SYMBOL;
            endcase
        end else if (i_rec.is_ac) begin
            unique case (r_idx)
                2'd0:    symbol = SYM_W'(i_rec.run);
                2'd1:    symbol = i_rec.folded[15:8];
                2'd2:    symbol = i_rec.folded[7:0];
                default: symbol = EOB_SYMBOL;
            endcase
        end
        last = ({1'b0, r_idx} == count - SCNT_W'(1));
    end

    assign advance = !i_empty && (!r_valid || i_ready);
    assign o_pop   = advance && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_idx   <= last ? '0 : r_idx + SIDX_W'(1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_symbol <= symbol;
            r_last   <= last;
            r_eob    <= last && i_rec.eob;
        end
    end

    assign o_valid        = r_valid;
    assign o_symbol       = r_symbol;
    assign o_last_of_item = r_last;
    assign o_block_end    = r_eob;

endmodule
